>>> rtl/pbt_pkg.sv
// Shared types, request codes and prefix helpers for the prefix ban table.
package pbt_pkg;

  localparam int ENTRIES  = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W   = 128;
  localparam int TIME_W   = 40;
  localparam int EXP_W    = TIME_W + 1;
  localparam int PFX_W    = 8;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 64;

  localparam logic [PFX_W-1:0] PFX_MAX = PFX_W'(ADDR_W);
  localparam logic [TIME_W-1:0] DEFAULT_BAN_RESET = TIME_W'(86400);

  // register index, taken from paddr[3]
  localparam logic REG_DEFAULT_BAN = 1'b0;

  localparam logic [2:0] REQ_CHECK_ADDR  = 3'd0;
  localparam logic [2:0] REQ_CHECK_EXACT = 3'd1;
  localparam logic [2:0] REQ_BAN         = 3'd2;
  localparam logic [2:0] REQ_UNBAN       = 3'd3;
  localparam logic [2:0] REQ_SWEEP       = 3'd4;
  localparam logic [2:0] REQ_CLEAR       = 3'd5;
  localparam logic [2:0] REQ_MARK_SAVED  = 3'd6;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [63:0]       addr_high;
    logic [63:0]       addr_low;
    logic [PFX_W-1:0]  prefix_len;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] ban_time;
    logic              absolute;
  } pbt_in_t;

  typedef struct packed {
    logic banned;
    logic removed;
    logic table_full;
    logic dirty;
  } pbt_out_t;

  typedef struct packed {
    logic [63:0]       net_high;
    logic [63:0]       net_low;
    logic [PFX_W-1:0]  prefix;
    logic [EXP_W-1:0]  expiry;
  } pbt_entry_t;

  function automatic logic [PFX_W-1:0] pfx_sat(input logic [PFX_W-1:0] p);
    return (p > PFX_MAX) ? PFX_MAX : p;
  endfunction

  // ones in the top p bits of a 128-bit address
  function automatic logic [ADDR_W-1:0] pfx_mask(input logic [PFX_W-1:0] p);
    logic [PFX_W-1:0] ps;
    ps = pfx_sat(p);
    return ~({ADDR_W{1'b1}} >> ps);
  endfunction

endpackage

>>> rtl/prefix_ban_table_with_expiry_unit.sv
// Prefix ban table with expiry: request sequencer, entry memory and APB register.
//
// Usage:
//   A request transfers on in_data when start is high and busy is low.
//   Every request gives exactly one result on out_data, marked by a
//   one-cycle out_valid strobe; the receiver must take it in that cycle.
//   default_ban_time is written over the APB port (byte address 0, 64-bit
//   data, low 40 bits used) while no request is in flight.
// Timing:
//   Entries live in a single-port-read, single-port-write memory with a
//   registered read. Each request walks the memory once, one entry per
//   cycle; busy stays high through S_SCAN, S_LAST and S_FIN, and out_valid
//   is registered from S_FIN. Clear and unused codes skip the walk and go
//   straight to S_FIN. A new request can be taken in the cycle its
//   predecessor's result is shown.
// Reset:
//   All entries invalid, dirty flag low, default_ban_time 86400. The entry
//   memory itself is not cleared; valid bits gate every read.
module prefix_ban_table_with_expiry_unit
  import pbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pbt_in_t           in_data,
  output logic              out_valid,
  output pbt_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t              state_r, state_nxt;
  pbt_in_t             req_r;
  logic [ADDR_W-1:0]   key_r;
  logic [PFX_W-1:0]    key_pfx_r;
  logic [EXP_W-1:0]    exp_r;
  logic [TIME_W-1:0]   default_ban_r;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  stale_mask_r;
  logic                unsaved_r, unsaved_nxt;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [IDX_W-1:0]    chk_idx_r;
  logic                chk_vld_r;
  logic                banned_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic                out_valid_r;
  pbt_out_t            out_data_r;
  pbt_out_t            fin_out;

  pbt_entry_t          mem [ENTRIES];
  pbt_entry_t          mem_rdata_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  pbt_entry_t          mem_wdata;

  logic                accept;
  logic                cfg_we;
  logic [ADDR_W-1:0]   in_addr;
  logic [EXP_W-1:0]    new_exp;
  logic                ent_valid;
  logic                addr_hit;
  logic                exact_hit;
  logic                live;
  logic                stale;
  logic                scan_we;
  logic                fin_we;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign in_addr = {in_data.addr_high, in_data.addr_low};

  // expiry of a ban, formed at transfer time
  always_comb begin
    if (in_data.ban_time == '0) begin
      new_exp = {1'b0, in_data.now} + {1'b0, default_ban_r};
    end else if (in_data.absolute) begin
      new_exp = {1'b0, in_data.ban_time};
    end else begin
      new_exp = {1'b0, in_data.now} + {1'b0, in_data.ban_time};
    end
  end

  // APB register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[3] == REG_DEFAULT_BAN);

  always_comb begin
    prdata = '0;
    if (paddr[3] == REG_DEFAULT_BAN) begin
      prdata = APB_DW'(default_ban_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_ban_r <= DEFAULT_BAN_RESET;
    end else if (cfg_we) begin
      default_ban_r <= pwdata[TIME_W-1:0];
    end
  end

  function automatic logic [ADDR_W-1:0] in_addr_r();
    return {req_r.addr_high, req_r.addr_low};
  endfunction

  // entry evaluation, in the cycle after its read
  always_comb begin
    ent_valid = valid_r[chk_idx_r];
    addr_hit  = ent_valid &&
                ((in_addr_r() & pfx_mask(mem_rdata_r.prefix)) ==
                 {mem_rdata_r.net_high, mem_rdata_r.net_low});
    exact_hit = ent_valid && (mem_rdata_r.prefix == key_pfx_r) &&
                ({mem_rdata_r.net_high, mem_rdata_r.net_low} == key_r);
    live      = {1'b0, req_r.now} < mem_rdata_r.expiry;
    stale     = {1'b0, req_r.now} > mem_rdata_r.expiry;
  end

  // a ban that hits keeps the later expiry; write back in place during the walk
  assign scan_we = chk_vld_r && (req_r.req_type == REQ_BAN) && exact_hit &&
                   (mem_rdata_r.expiry < exp_r);
  assign fin_we  = (state_r == S_FIN) && (req_r.req_type == REQ_BAN) && !hit_r &&
                   free_found_r;

  always_comb begin
    mem_we    = scan_we || fin_we;
    mem_waddr = fin_we ? free_idx_r : chk_idx_r;
    mem_wdata = '{net_high: key_r[ADDR_W-1:64], net_low: key_r[63:0],
                  prefix: key_pfx_r, expiry: exp_r};
  end

  // Reads run ahead of evaluation and writes go to an index already read,
  // so no access within a walk sees a stale word.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[rd_idx_r];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if ((in_data.req_type == REQ_CLEAR) || (in_data.req_type > REQ_MARK_SAVED)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:  state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // end-of-request table and flag update
  always_comb begin
    valid_nxt   = valid_r;
    unsaved_nxt = unsaved_r;
    fin_out     = '0;
    case (req_r.req_type)
      REQ_CHECK_ADDR, REQ_CHECK_EXACT: begin
        fin_out.banned = banned_r;
      end
      REQ_BAN: begin
        if (hit_r) begin
          unsaved_nxt = 1'b1;
        end else if (free_found_r) begin
          valid_nxt[free_idx_r] = 1'b1;
          unsaved_nxt = 1'b1;
        end else begin
          fin_out.table_full = 1'b1;
        end
      end
      REQ_UNBAN: begin
        if (hit_r) begin
          valid_nxt = valid_r & ~stale_mask_r;
          valid_nxt[hit_idx_r] = 1'b0;
          unsaved_nxt = 1'b1;
          fin_out.removed = 1'b1;
        end
      end
      REQ_SWEEP: begin
        valid_nxt = valid_r & ~stale_mask_r;
        if (|stale_mask_r) begin
          unsaved_nxt = 1'b1;
        end
      end
      REQ_CLEAR: begin
        valid_nxt   = '0;
        unsaved_nxt = 1'b1;
      end
      REQ_MARK_SAVED: begin
        valid_nxt   = valid_r & ~stale_mask_r;
        unsaved_nxt = 1'b0;
      end
      default: ;
    endcase
    fin_out.dirty = unsaved_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      unsaved_r   <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= (state_r == S_SCAN);
      out_valid_r <= (state_r == S_FIN);
      if (state_r == S_FIN) begin
        valid_r   <= valid_nxt;
        unsaved_r <= unsaved_nxt;
      end
    end
  end

  // request payload and per-walk scratch
  always_ff @(posedge clk) begin
    chk_idx_r <= rd_idx_r;
    if (state_r == S_FIN) begin
      out_data_r <= fin_out;
    end
    if (accept) begin
      req_r        <= in_data;
      key_r        <= in_addr & pfx_mask(in_data.prefix_len);
      key_pfx_r    <= pfx_sat(in_data.prefix_len);
      exp_r        <= new_exp;
      rd_idx_r     <= '0;
      banned_r     <= 1'b0;
      hit_r        <= 1'b0;
      hit_idx_r    <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      stale_mask_r <= '0;
    end else begin
      if (state_r == S_SCAN) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (chk_vld_r) begin
        case (req_r.req_type)
          REQ_CHECK_ADDR: begin
            if (addr_hit && live) begin
              banned_r <= 1'b1;
            end
          end
          REQ_CHECK_EXACT: begin
            if (exact_hit && live) begin
              banned_r <= 1'b1;
            end
          end
          default: ;
        endcase
        if (exact_hit) begin
          hit_r     <= 1'b1;
          hit_idx_r <= chk_idx_r;
        end
        if (!ent_valid && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= chk_idx_r;
        end
        if (ent_valid && stale) begin
          stale_mask_r[chk_idx_r] <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_follows_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FIN))
    else $error("result strobe without a finishing cycle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request transfer did not raise busy");

  a_scan_write_only_ban: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r != S_FIN)) |-> (req_r.req_type == REQ_BAN))
    else $error("entry memory written during a walk by a non-ban request");

  a_removed_sets_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.removed) |-> out_data.dirty)
    else $error("unban removed an entry but dirty is low");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_data.banned && out_data.table_full) ||
                    (out_data.banned && out_data.removed) ||
                    (out_data.removed && out_data.table_full)))
    else $error("more than one request flag raised in one result");

endmodule

>>> sim/pbt_checker.sv
`timescale 1ns / 1ps
// Checker for the prefix ban table: tracks the table, predicts result flags, compares.
module pbt_checker
  import pbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  pbt_in_t           in_data,
  input  logic              out_valid,
  input  pbt_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                hits,
  output int                drops,
  output int                unbans
);

  localparam logic [APB_AW-1:0] DFLT_BAN_ADDR = APB_AW'({REG_DEFAULT_BAN, 3'b000});

  logic              live [ENTRIES];
  pbt_entry_t        tab  [ENTRIES];
  logic              unsaved;
  logic [TIME_W-1:0] dflt_ban;
  pbt_out_t          exp_flags_q [$];
  int                err_cnt   = 0;
  int                chk_cnt   = 0;
  int                hit_cnt   = 0;
  int                drop_cnt  = 0;
  int                unban_cnt = 0;
  string             fname [4] = '{"dirty", "table_full", "removed", "banned"};

  // ones in the top p bits; p is already clipped to 128
  function automatic logic [ADDR_W-1:0] top_bits(input logic [PFX_W-1:0] p);
    if (p == '0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - int'(p));
  endfunction

  function automatic int find_key(input logic [ADDR_W-1:0] key, input logic [PFX_W-1:0] p);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (live[i] && tab[i].prefix == p && {tab[i].net_high, tab[i].net_low} == key)
        return i;
    return -1;
  endfunction

  // drop entries whose expiry lies strictly before t
  function automatic void expire_old(input logic [TIME_W-1:0] t);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (live[i] && {1'b0, t} > tab[i].expiry) begin
        live[i] = 1'b0;
        unsaved = 1'b1;
      end
  endfunction

  function automatic pbt_out_t apply_request(input pbt_in_t r);
    pbt_out_t          res;
    logic [PFX_W-1:0]  p;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] key;
    logic [EXP_W-1:0]  exp_t;
    int                hit;
    int                slot;
    int                i;
    res  = '0;
    p    = (r.prefix_len > PFX_W'(ADDR_W)) ? PFX_W'(ADDR_W) : r.prefix_len;
    addr = {r.addr_high, r.addr_low};
    key  = addr & top_bits(p);
    hit  = find_key(key, p);
    case (r.req_type)
      REQ_CHECK_ADDR: begin
        for (i = 0; i < ENTRIES; i++)
          if (live[i] && (addr & top_bits(tab[i].prefix)) == {tab[i].net_high, tab[i].net_low}
              && {1'b0, r.now} < tab[i].expiry)
            res.banned = 1'b1;
      end
      REQ_CHECK_EXACT: begin
        if (hit >= 0 && {1'b0, r.now} < tab[hit].expiry) res.banned = 1'b1;
      end
      REQ_BAN: begin
        if (r.ban_time == '0) exp_t = {1'b0, r.now} + {1'b0, dflt_ban};
        else if (r.absolute) exp_t = {1'b0, r.ban_time};
        else exp_t = {1'b0, r.now} + {1'b0, r.ban_time};
        if (hit >= 0) begin
          if (tab[hit].expiry < exp_t) tab[hit].expiry = exp_t;
          unsaved = 1'b1;
        end else begin
          slot = -1;
          for (i = ENTRIES - 1; i >= 0; i--)
            if (!live[i]) slot = i;
          if (slot < 0) begin
            res.table_full = 1'b1;
          end else begin
            live[slot]         = 1'b1;
            tab[slot].net_high = key[127:64];
            tab[slot].net_low  = key[63:0];
            tab[slot].prefix   = p;
            tab[slot].expiry   = exp_t;
            unsaved            = 1'b1;
          end
        end
      end
      REQ_UNBAN: begin
        if (hit >= 0) begin
          live[hit]   = 1'b0;
          unsaved     = 1'b1;
          res.removed = 1'b1;
          expire_old(r.now);
        end
      end
      REQ_SWEEP: expire_old(r.now);
      REQ_CLEAR: begin
        for (i = 0; i < ENTRIES; i++) live[i] = 1'b0;
        unsaved = 1'b1;
      end
      REQ_MARK_SAVED: begin
        expire_old(r.now);
        unsaved = 1'b0;
      end
      default: ;
    endcase
    res.dirty = unsaved;
    return res;
  endfunction

  always @(posedge clk) begin : track
    pbt_out_t want;
    pbt_out_t got;
    int       f;
    if (!rst_n) begin
      for (f = 0; f < ENTRIES; f++) live[f] = 1'b0;
      unsaved  = 1'b0;
      dflt_ban = DEFAULT_BAN_RESET;
      exp_flags_q.delete();
    end else begin
      // result first: a new request may transfer at the same edge
      if (out_valid) begin
        got = out_data;
        if (exp_flags_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %b", $time, got);
          err_cnt++;
        end else begin
          want = exp_flags_q.pop_front();
          chk_cnt++;
          for (f = 0; f < 4; f++)
            if (got[f] !== want[f]) begin
              $display("%0t: %s mismatch, expected %b, got %b", $time, fname[f], want[f],
                       got[f]);
              err_cnt++;
            end
        end
      end
      if (psel && penable && pwrite && pready && paddr == DFLT_BAN_ADDR)
        dflt_ban = pwdata[TIME_W-1:0];
      if (start && !busy) begin
        want = apply_request(in_data);
        if (want.banned) hit_cnt++;
        if (want.table_full) drop_cnt++;
        if (want.removed) unban_cnt++;
        exp_flags_q = {exp_flags_q, want};
      end
    end
    errors  <= err_cnt;
    pending <= exp_flags_q.size();
    checked <= chk_cnt;
    hits    <= hit_cnt;
    drops   <= drop_cnt;
    unbans  <= unban_cnt;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the prefix ban table: clock, reset, request and register stimulus.
module tb_top;
  import pbt_pkg::*;

  localparam int                WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]        REQ_UNUSED     = 3'd7;
  localparam logic [TIME_W-1:0] TIME_MAX       = '1;
  localparam logic [APB_AW-1:0] DFLT_BAN_ADDR  = APB_AW'({REG_DEFAULT_BAN, 3'b000});

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  pbt_in_t           in_data = '0;
  logic              out_valid;
  pbt_out_t          out_data;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int errors, pending, checked, hits, drops, unbans;
  int idle_cycles = 0;
  int burst_left  = 0;
  int settings    = 0;

  // keys for the random part: raw network and raw length
  logic [ADDR_W-1:0] pool_net [128];
  logic [PFX_W-1:0]  pool_len [128];
  int                pool_n;
  logic              long_bans = 1'b0;
  logic [TIME_W-1:0] t_now     = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  prefix_ban_table_with_expiry_unit dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pbt_checker chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .checked, .hits, .drops, .unbans
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [TIME_W-1:0] rand40();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ADDR_W-1:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [PFX_W-1:0] pick_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2) return '0;
    if (sel < 10) return PFX_W'(128);
    if (sel < 15) return PFX_W'($urandom_range(129, 255));
    if (sel < 20) return PFX_W'(64);
    if (sel < 25) return PFX_W'(65);
    if (sel < 28) return PFX_W'(1);
    if (sel < 30) return PFX_W'(127);
    return PFX_W'($urandom_range(1, 127));
  endfunction

  // one request transfer, with bursts and random gaps in front
  task automatic issue(input pbt_in_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 120);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data <= r;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send(input logic [2:0] kind, input logic [ADDR_W-1:0] a,
                      input logic [PFX_W-1:0] len, input logic [TIME_W-1:0] at,
                      input logic [TIME_W-1:0] bt, input logic abs_t);
    pbt_in_t r;
    r.req_type   = kind;
    r.addr_high  = a[127:64];
    r.addr_low   = a[63:0];
    r.prefix_len = len;
    r.now        = at;
    r.ban_time   = bt;
    r.absolute   = abs_t;
    issue(r);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_default_ban(input logic [TIME_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DFLT_BAN_ADDR;
    pwdata  <= {24'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  // some keys nest inside earlier ones so prefixes overlap
  task automatic refill_pool(input int n);
    int i, j;
    pool_n = n;
    for (i = 0; i < n; i++) begin
      pool_len[i] = pick_len();
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        j = $urandom_range(0, i - 1);
        pool_net[i] = pool_net[j] ^ (rand128() >> pool_len[j]);
      end else begin
        pool_net[i] = rand128();
      end
    end
  endtask

  task automatic issue_random();
    int                sel, k, ban_cut;
    logic [2:0]        kind;
    logic [ADDR_W-1:0] a;
    logic [TIME_W-1:0] bt;
    logic              abs_t;
    sel = $urandom_range(0, 299);
    if (sel == 0 && !long_bans) t_now = rand40();
    else if (sel == 1 && !long_bans) t_now = TIME_MAX - TIME_W'($urandom_range(0, 50));
    else t_now = t_now + TIME_W'($urandom_range(0, 12));

    ban_cut = long_bans ? 50 : 30;
    sel = $urandom_range(0, 99);
    if (sel < ban_cut) kind = REQ_BAN;
    else if (sel < ban_cut + 22) kind = REQ_CHECK_ADDR;
    else if (sel < ban_cut + 32) kind = REQ_CHECK_EXACT;
    else if (sel < ban_cut + 40) kind = REQ_UNBAN;
    else if (sel < ban_cut + 45) kind = REQ_SWEEP;
    else if (sel < ban_cut + 50) kind = REQ_MARK_SAVED;
    else if (sel < ban_cut + 52) kind = long_bans ? REQ_SWEEP : REQ_CLEAR;
    else if (sel < ban_cut + 54) kind = REQ_UNUSED;
    else begin
      // noise: every field random
      send(3'($urandom), rand128(), PFX_W'($urandom), rand40(), rand40(), 1'($urandom));
      return;
    end

    k = $urandom_range(0, pool_n - 1);
    a = pool_net[k] ^ (rand128() >> pool_len[k]);
    if (kind == REQ_CHECK_ADDR && $urandom_range(0, 4) == 0) a = rand128();

    abs_t = 1'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 15) bt = '0;
    else if (sel < 25) bt = rand40();
    else if (sel < 28) bt = TIME_MAX;
    else if (sel < 40) begin
      bt    = t_now + TIME_W'($urandom_range(0, 400));
      abs_t = 1'b1;
    end else begin
      bt    = long_bans ? TIME_W'($urandom_range(1000, 100000)) : TIME_W'($urandom_range(1, 400));
      abs_t = 1'b0;
    end
    send(kind, a, pool_len[k], t_now, bt, abs_t);
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] dflt, input int keys, input logic longb,
                           input int items);
    drain();
    write_default_ban(dflt);
    refill_pool(keys);
    long_bans = longb;
    repeat (items) issue_random();
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] a, b, c;
    a = 128'h2001_0db8_0000_0000_0000_0000_0000_0001;
    b = 128'h3ffe_1234_5678_9abc_def0_0000_0000_0000;
    c = 128'h0000_0000_0000_0000_0000_0000_0000_0001;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    t_now = 40'd1000;
    send(REQ_CHECK_ADDR, a, 8'd128, t_now, '0, 1'b0);           // empty table
    send(REQ_BAN, a, 8'd32, t_now, '0, 1'b0);                   // default duration
    send(REQ_CHECK_ADDR, a ^ 128'h0000_0000_ffff_0000_0000_0000_0000_ffff, 8'd128, t_now,
         '0, 1'b0);
    send(REQ_CHECK_EXACT, a | 128'hff, 8'd32, t_now, '0, 1'b0); // host bits masked off
    send(REQ_CHECK_EXACT, a, 8'd48, t_now, '0, 1'b0);           // other length misses
    send(REQ_BAN, '1, 8'd128, t_now, TIME_MAX, 1'b1);
    send(REQ_BAN, '1, 8'd255, t_now, 40'd10, 1'b0);             // clips to 128, keeps expiry
    send(REQ_BAN, '0, 8'd0, t_now, 40'd5, 1'b0);                // covers every address
    send(REQ_CHECK_ADDR, rand128(), 8'd128, t_now, '0, 1'b0);
    send(REQ_BAN, {64'hffff_ffff_ffff_ffff, 64'h1234_5678_9abc_def0}, 8'd64, t_now, 40'd1,
         1'b0);
    send(REQ_BAN, {64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000}, 8'd65, t_now, 40'd1,
         1'b0);
    send(REQ_MARK_SAVED, '0, 8'd0, t_now, '0, 1'b0);
    send(REQ_SWEEP, '0, 8'd0, t_now + 40'd7, '0, 1'b0);
    send(REQ_CHECK_ADDR, {64'hffff_ffff_ffff_ffff, 64'h0}, 8'd128, t_now + 40'd7, '0, 1'b0);
    send(REQ_UNBAN, a, 8'd32, t_now + 40'd7, '0, 1'b0);
    send(REQ_UNBAN, a, 8'd32, t_now + 40'd7, '0, 1'b0);        // already gone
    send(REQ_BAN, b, 8'd96, 40'd2000, 40'd10, 1'b0);
    send(REQ_CHECK_EXACT, b, 8'd96, 40'd2009, '0, 1'b0);
    send(REQ_CHECK_EXACT, b, 8'd96, 40'd2010, '0, 1'b0);        // expired at its expiry
    send(REQ_SWEEP, '0, 8'd0, 40'd2010, '0, 1'b0);              // not yet past expiry
    send(REQ_SWEEP, '0, 8'd0, 40'd2011, '0, 1'b0);
    send(REQ_UNUSED, rand128(), 8'd17, 40'd2011, rand40(), 1'b1);
    send(REQ_BAN, c, 8'd128, TIME_MAX, TIME_MAX, 1'b0);         // expiry needs bit 40
    send(REQ_CHECK_ADDR, c, 8'd128, TIME_MAX, '0, 1'b0);
    send(REQ_CLEAR, '0, 8'd0, TIME_MAX, '0, 1'b0);

    t_now = 40'd5000;
    run_phase(DEFAULT_BAN_RESET, 24, 1'b0, 238);
    run_phase(TIME_MAX, 100, 1'b1, 238);
    run_phase(40'd1, 40, 1'b0, 238);
    run_phase(40'd0, 16, 1'b0, 238);
    run_phase(rand40(), 100, 1'b1, 238);
    run_phase(40'd300, 60, 1'b0, 238);

    drain();
    repeat (ENTRIES + 16) @(posedge clk);
    $display("Covered %0d requests under %0d default ban settings, directed and random.",
             checked, settings);
    $display("%0d lookups hit a live ban, %0d bans dropped on a full table, %0d unbans hit.",
             hits, drops, unbans);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/pbt_pkg.sv
rtl/prefix_ban_table_with_expiry_unit.sv
sim/pbt_checker.sv
sim/tb_top.sv
